// ===== src/pwc_pkg.sv =====
// pwc_pkg: shared types and constants of the pixel write combiner
// beat structs for the pixel and burst channels, operation and mode codes,
// sequencer states; no dependencies
`default_nettype none

package pwc_pkg;

    // field widths
    localparam int unsigned COORD_W  = 11;
    localparam int unsigned COLOUR_W = 16;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BYTES_W  = 8;
    localparam int unsigned WIDX_W   = 5;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // pixel modes
    localparam logic MODE_RGB16 = 1'b0;
    localparam logic MODE_PAL8  = 1'b1;

    // one pixel request beat
    typedef struct packed {
        logic                operation;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [COLOUR_W-1:0] colour;
    } req_beat_t;

    // one burst word beat
    typedef struct packed {
        logic [COORD_W-1:0] burst_x;
        logic [COORD_W-1:0] burst_y;
        logic [BYTES_W-1:0] byte_count;
        logic [WIDX_W-1:0]  word_index;
        logic [WORD_W-1:0]  packed_word;
        logic               last_word;
    } burst_beat_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CAPT,
        ST_SHOW,
        ST_LOAD
    } pwc_state_t;

endpackage : pwc_pkg

`default_nettype wire

// ===== src/pwc_ram.sv =====
// pwc_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module pwc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule : pwc_ram

`default_nettype wire

// ===== src/pixel_write_combiner_core.sv =====
// pixel_write_combiner_core: packs pixel writes into a word buffer, emits bursts
// timing: a pixel that extends or starts a run is taken in ST_IDLE; a burst's first
// beat is offered after the ST_READ and ST_CAPT states, and each further beat after another ST_CAPT,
// since one read at a time goes through the buffer ram's registered port
// reset: asynchronous active-low, clears mode, run and sequencer state; buffer ram not cleared
// depends on pwc_pkg and pwc_ram
`default_nettype none

module pixel_write_combiner_core
    import pwc_pkg::*;
#(
    parameter int unsigned BUFFER_WORDS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire req_beat_t req,
    output logic       burst_valid,
    input  wire logic  burst_ready,
    output burst_beat_t burst
);

    localparam int unsigned CAP16 = BUFFER_WORDS * 2;
    localparam int unsigned CAP8  = BUFFER_WORDS * 4;
    localparam int unsigned CW    = $clog2(CAP8 + 1);
    localparam int unsigned AW    = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
    localparam int unsigned BW_W  = CW + 1;
    localparam int unsigned SW    = ((CW > COORD_W) ? CW : COORD_W) + 1;

    pwc_state_t          state_reg, state_next;
    logic                mode_reg, mode_next;
    logic                run_valid_reg, run_valid_next;
    logic [COORD_W-1:0]  run_x_reg, run_x_next;
    logic [COORD_W-1:0]  run_y_reg, run_y_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [WORD_W-1:0]   cur_word_reg, cur_word_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [COORD_W-1:0]  pend_x_reg, pend_x_next;
    logic [COORD_W-1:0]  pend_y_reg, pend_y_next;
    logic [COLOUR_W-1:0] pend_colour_reg, pend_colour_next;
    logic [BW_W-1:0]     bytes_reg, bytes_next;
    logic [AW-1:0]       last_idx_reg, last_idx_next;
    logic [AW-1:0]       k_reg, k_next;
    logic [WORD_W-1:0]   word_reg, word_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic [CW-1:0]       cap;
    logic [CW-1:0]       pk_cnt;
    logic [COLOUR_W-1:0] pk_colour;
    logic [1:0]          pk_ofs;
    logic [WORD_W-1:0]   pk_val;
    logic [WORD_W-1:0]   pk_word;
    logic [AW-1:0]       pk_idx;
    logic [CW-1:0]       pk_cnt_inc;
    logic [CW-1:0]       ecnt;
    logic [BW_W-1:0]     e_bytes;
    logic [BW_W-1:0]     e_round;
    logic [AW-1:0]       e_last;
    logic                cont;

    // burst word buffer
    pwc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BUFFER_WORDS)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // run capacity in pixels
    assign cap = (mode_reg == MODE_PAL8) ? CW'(CAP8) : CW'(CAP16);

    // pixel packing: merge into the current word, forwarded from cur_word_reg
    always_comb
    begin
        pk_ofs  = (mode_reg == MODE_PAL8) ? pk_cnt[1:0] : {pk_cnt[0], 1'b0};
        pk_val  = (mode_reg == MODE_PAL8) ? {24'b0, pk_colour[7:0]} : {16'b0, pk_colour};
        pk_word = (pk_ofs == 2'd0) ? pk_val : (cur_word_reg | (pk_val << {pk_ofs, 3'b000}));
        pk_idx  = (mode_reg == MODE_PAL8) ? AW'(pk_cnt >> 2) : AW'(pk_cnt >> 1);
        pk_cnt_inc = pk_cnt + CW'(1);
    end

    // burst size from the run length
    always_comb
    begin
        e_bytes = (mode_reg == MODE_PAL8) ? BW_W'(ecnt) : {ecnt, 1'b0};
        e_round = e_bytes + BW_W'(3);
        e_last  = AW'((e_round >> 2) - BW_W'(1));
    end

    // pixel continues the pending run
    assign cont = run_valid_reg && (run_y_reg == req.pixel_y)
                  && ((SW'(run_x_reg) + SW'(cnt_reg)) == SW'(req.pixel_x))
                  && (cnt_reg < cap);

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        run_valid_next   = run_valid_reg;
        run_x_next       = run_x_reg;
        run_y_next       = run_y_reg;
        cnt_next         = cnt_reg;
        cur_word_next    = cur_word_reg;
        pend_valid_next  = pend_valid_reg;
        pend_x_next      = pend_x_reg;
        pend_y_next      = pend_y_reg;
        pend_colour_next = pend_colour_reg;
        bytes_next       = bytes_reg;
        last_idx_next    = last_idx_reg;
        k_next           = k_reg;
        word_next        = word_reg;
        req_ready        = 1'b0;
        ram_we           = 1'b0;
        ram_raddr        = k_reg;
        pk_cnt           = cnt_reg;
        pk_colour        = req.colour;
        ecnt             = cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req.operation == OP_FLUSH)
                    begin
                        // flush the pending run, if any
                        if (run_valid_reg)
                        begin
                            bytes_next     = e_bytes;
                            last_idx_next  = e_last;
                            k_next         = '0;
                            run_valid_next = 1'b0;
                            state_next     = ST_READ;
                        end
                    end
                    else if (cont)
                    begin
                        // extend the run, emit when the buffer fills
                        ram_we        = 1'b1;
                        cur_word_next = pk_word;
                        cnt_next      = pk_cnt_inc;
                        if (pk_cnt_inc == cap)
                        begin
                            ecnt           = pk_cnt_inc;
                            bytes_next     = e_bytes;
                            last_idx_next  = e_last;
                            k_next         = '0;
                            run_valid_next = 1'b0;
                            state_next     = ST_READ;
                        end
                    end
                    else if (run_valid_reg)
                    begin
                        // run broken: emit it, hold the new pixel for later
                        bytes_next       = e_bytes;
                        last_idx_next    = e_last;
                        k_next           = '0;
                        run_valid_next   = 1'b0;
                        pend_valid_next  = 1'b1;
                        pend_x_next      = req.pixel_x;
                        pend_y_next      = req.pixel_y;
                        pend_colour_next = req.colour;
                        state_next       = ST_READ;
                    end
                    else
                    begin
                        // start a new run
                        pk_cnt         = '0;
                        ram_we         = 1'b1;
                        cur_word_next  = pk_word;
                        cnt_next       = CW'(1);
                        run_x_next     = req.pixel_x;
                        run_y_next     = req.pixel_y;
                        run_valid_next = 1'b1;
                    end
                end
            end

            ST_READ:
            begin
                ram_raddr  = k_reg;
                state_next = ST_CAPT;
            end

            ST_CAPT:
            begin
                word_next  = ram_rdata;
                state_next = ST_SHOW;
            end

            ST_SHOW:
            begin
                if (burst_ready)
                begin
                    if (k_reg == last_idx_reg)
                    begin
                        state_next = pend_valid_reg ? ST_LOAD : ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        ram_raddr  = k_reg + AW'(1);
                        state_next = ST_CAPT;
                    end
                end
            end

            ST_LOAD:
            begin
                // held pixel opens the new run
                pk_cnt          = '0;
                pk_colour       = pend_colour_reg;
                ram_we          = 1'b1;
                cur_word_next   = pk_word;
                cnt_next        = CW'(1);
                run_x_next      = pend_x_reg;
                run_y_next      = pend_y_reg;
                run_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // mode write drops the pending run
        if (cfg_we)
        begin
            mode_next      = cfg_wdata;
            run_valid_next = 1'b0;
        end
    end

    assign ram_waddr = pk_idx;
    assign ram_wdata = pk_word;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_RGB16;
            run_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            last_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            run_valid_reg  <= run_valid_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            k_reg          <= k_next;
            last_idx_reg   <= last_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        run_x_reg       <= run_x_next;
        run_y_reg       <= run_y_next;
        cur_word_reg    <= cur_word_next;
        pend_x_reg      <= pend_x_next;
        pend_y_reg      <= pend_y_next;
        pend_colour_reg <= pend_colour_next;
        bytes_reg       <= bytes_next;
        word_reg        <= word_next;
    end

    // burst beat
    assign burst_valid       = (state_reg == ST_SHOW);
    assign burst.burst_x     = run_x_reg;
    assign burst.burst_y     = run_y_reg;
    assign burst.byte_count  = BYTES_W'(bytes_reg);
    assign burst.word_index  = WIDX_W'(k_reg);
    assign burst.packed_word = word_reg;
    assign burst.last_word   = (k_reg == last_idx_reg);

`ifndef ASSERT_OFF
    // no pixel is taken while a burst beat is on offer
    a_ready_no_burst: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !burst_valid)
        else $error("pixel accepted while burst beat pending");

    // the final beat ends the burst
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_valid && burst_ready && burst.last_word) |=> !burst_valid)
        else $error("burst continued past last word");

    // a pending run never reaches capacity
    a_run_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> (cnt_reg < cap))
        else $error("pending run at or above capacity");

    // buffer is not written while a read is in flight
    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CAPT) |-> !ram_we)
        else $error("buffer write during burst read");
`endif

endmodule : pixel_write_combiner_core

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for pixel_write_combiner_core in both pixel modes
// predicts burst beats from accepted pixel beats and checks them in order
// depends on pwc_pkg and the core rtl

module tb_top;
    import pwc_pkg::*;

    localparam int unsigned BUF_WORDS  = 32;
    localparam int unsigned SETTLE_CYC = 12;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic        cfg_wdata   = 1'b0;
    logic        req_valid   = 1'b0;
    logic        req_ready;
    req_beat_t   req_in      = '0;
    logic        burst_valid;
    logic        burst_ready = 1'b0;
    burst_beat_t burst_out;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // mirror of the combiner state
    logic        mode_m   = MODE_RGB16;
    logic        run_open = 1'b0;
    int unsigned run_x    = 0;
    int unsigned run_y    = 0;
    int unsigned run_len  = 0;
    logic [WORD_W-1:0] word_buf [BUF_WORDS];
    burst_beat_t pending_beats [$];

    pixel_write_combiner_core #(
        .BUFFER_WORDS (BUF_WORDS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req_in),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst_out)
    );

    always #1 clk = ~clk;

    // pixels a run can hold before it goes out on its own
    function automatic int unsigned run_capacity();
        return (mode_m == MODE_PAL8) ? BUF_WORDS * 4 : BUF_WORDS * 2;
    endfunction

    // turn the open run into burst beats, lowest word first
    function automatic void emit_run_beats();
        int unsigned nbytes;
        int unsigned nwords;
        burst_beat_t b;
        nbytes = (mode_m == MODE_PAL8) ? run_len : run_len * 2;
        nwords = (nbytes + 3) / 4;
        if (nwords > BUF_WORDS)
            nwords = BUF_WORDS;
        for (int unsigned k = 0; k < nwords; k++)
        begin
            b.burst_x     = run_x[COORD_W-1:0];
            b.burst_y     = run_y[COORD_W-1:0];
            b.byte_count  = nbytes[BYTES_W-1:0];
            b.word_index  = k[WIDX_W-1:0];
            b.packed_word = word_buf[k];
            b.last_word   = (k + 1 == nwords);
            pending_beats.push_back(b);
        end
        run_open = 1'b0;
    endfunction

    // place one pixel at the end of the run, lowest pixel in the low bits
    function automatic void pack_pixel(logic [COLOUR_W-1:0] colour);
        int unsigned idx;
        int unsigned lane;
        if (mode_m == MODE_PAL8)
        begin
            idx  = (run_len >> 2) % BUF_WORDS;
            lane = run_len & 3;
            if (lane == 0)
                word_buf[idx] = {24'd0, colour[7:0]};
            else
                word_buf[idx] = word_buf[idx] | (32'(colour[7:0]) << (lane * 8));
        end
        else
        begin
            idx = (run_len >> 1) % BUF_WORDS;
            if (run_len & 1)
                word_buf[idx] = word_buf[idx] | (32'(colour) << 16);
            else
                word_buf[idx] = {16'd0, colour};
        end
        run_len++;
    endfunction

    // update the mirror for one accepted pixel beat
    function automatic void predict_bursts(req_beat_t b);
        if (b.operation == OP_FLUSH)
        begin
            if (run_open)
                emit_run_beats();
            return;
        end
        // extends the run: same row, next column, no wrap past the last column
        if (run_open && run_y == 32'(b.pixel_y) && run_x + run_len == 32'(b.pixel_x)
            && run_len < run_capacity())
        begin
            pack_pixel(b.colour);
            if (run_len >= run_capacity())
                emit_run_beats();
            return;
        end
        // breaks the run: old one goes out, new one of one pixel starts
        if (run_open)
            emit_run_beats();
        run_open = 1'b1;
        run_x    = 32'(b.pixel_x);
        run_y    = 32'(b.pixel_y);
        run_len  = 0;
        pack_pixel(b.colour);
        if (run_len >= run_capacity())
            emit_run_beats();
    endfunction

    // one pixel beat, after a random gap; valid stays up until accepted
    task automatic send_req(input logic op, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [COLOUR_W-1:0] c);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_in    <= '{operation: op, pixel_x: x, pixel_y: y, colour: c};
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_bursts(req_in);
    endtask

    // hold the pixel side until every predicted beat is out and the core settles
    task automatic wait_bursts_done();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // mode write while idle; drops any open run
    task automatic program_mode(input logic mode);
        wait_bursts_done();
        cfg_wdata <= mode;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mode_m   = mode;
        run_open = 1'b0;
    endtask

    // burst side backpressure
    always @(negedge clk)
        burst_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // compare every burst beat with the oldest prediction
    always @(posedge clk)
    begin
        burst_beat_t want;
        if (rst_n && burst_valid && burst_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: burst beat expected none, got %p", $time, burst_out);
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("burst_x", want.burst_x, burst_out.burst_x);
                check_field("burst_y", want.burst_y, burst_out.burst_y);
                check_field("byte_count", want.byte_count, burst_out.byte_count);
                check_field("word_index", want.word_index, burst_out.word_index);
                check_field("packed_word", want.packed_word, burst_out.packed_word);
                check_field("last_word", want.last_word, burst_out.last_word);
            end
        end
    end

    // flush with nothing open, before and after a burst
    task automatic test_flush_idle();
        program_mode(MODE_RGB16);
        send_req(OP_FLUSH, 11'h7FF, 11'h7FF, 16'hFFFF);
        send_req(OP_WRITE, 11'd0, 11'd0, 16'h0000);
        send_req(OP_FLUSH, 11'd0, 11'd0, 16'h0000);
        send_req(OP_FLUSH, 11'd0, 11'd0, 16'h0000);
    endtask

    // run ending on the last column must not continue at column zero
    task automatic test_column_edges();
        send_req(OP_WRITE, 11'd2047, 11'd2047, 16'hFFFF);
        send_req(OP_WRITE, 11'd0, 11'd2047, 16'h0000);
        send_req(OP_WRITE, 11'd1, 11'd2047, 16'h1234);
        send_req(OP_FLUSH, 11'd5, 11'd5, 16'h5555);
    endtask

    // odd pixel counts, column gap and row change both break the run
    task automatic test_run_breaks();
        send_req(OP_WRITE, 11'd5, 11'd3, 16'hAAAA);
        send_req(OP_WRITE, 11'd6, 11'd3, 16'h5555);
        send_req(OP_WRITE, 11'd7, 11'd3, 16'h0F0F);
        send_req(OP_WRITE, 11'd9, 11'd3, 16'h1111);
        send_req(OP_WRITE, 11'd10, 11'd4, 16'h2222);
        send_req(OP_FLUSH, 11'd0, 11'd0, 16'h0000);
    endtask

    // a mode write drops the open run without a burst
    task automatic test_mode_drop();
        send_req(OP_WRITE, 11'd100, 11'd100, 16'hBEEF);
        program_mode(MODE_PAL8);
        send_req(OP_FLUSH, 11'd100, 11'd100, 16'hBEEF);
    endtask

    // palette packing: only low byte kept, four pixels per word
    task automatic test_palette_pack();
        send_req(OP_WRITE, 11'd2045, 11'd0, 16'h00AB);
        send_req(OP_WRITE, 11'd2046, 11'd0, 16'hFFCD);
        send_req(OP_WRITE, 11'd2047, 11'd0, 16'h0012);
        send_req(OP_WRITE, 11'd0, 11'd0, 16'h7701);
        send_req(OP_WRITE, 11'd1, 11'd0, 16'h8802);
        send_req(OP_WRITE, 11'd2, 11'd0, 16'h9903);
        send_req(OP_WRITE, 11'd3, 11'd0, 16'hAA04);
        send_req(OP_WRITE, 11'd4, 11'd0, 16'hBB05);
        send_req(OP_FLUSH, 11'd0, 11'd0, 16'h0000);
    endtask

    // random runs with random ends, stray beats and one mid-phase drain
    task automatic test_random_runs(input logic mode, input int idle_pct, input int stall_pct,
                                    input int n_items, input bit fill_first);
        int sent;
        int len;
        int pick;
        bit drained;
        int unsigned cap;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        program_mode(mode);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        cap     = run_capacity();
        sent    = 0;
        drained = 1'b0;
        // one run that fills the buffer exactly
        if (fill_first)
        begin
            x0 = COORD_W'($urandom_range(0, 2048 - cap));
            y0 = COORD_W'($urandom_range(0, 2047));
            for (int i = 0; i < int'(cap); i++)
                send_req(OP_WRITE, x0 + COORD_W'(i), y0, COLOUR_W'($urandom_range(0, 65535)));
            sent = int'(cap);
        end
        while (sent < n_items)
        begin
            if (!drained && sent >= n_items / 2)
            begin
                wait_bursts_done();
                drained = 1'b1;
            end
            pick = int'($urandom_range(0, 99));
            if (pick < 12)
            begin
                // stray beat, either operation, anywhere
                send_req(1'($urandom_range(0, 1)), COORD_W'($urandom_range(0, 2047)),
                         COORD_W'($urandom_range(0, 2047)), COLOUR_W'($urandom_range(0, 65535)));
                sent++;
            end
            else
            begin
                // contiguous run, now and then long enough to fill the buffer
                if ($urandom_range(0, 24) == 0)
                    len = int'($urandom_range(cap - 2, cap + 1));
                else
                    len = int'($urandom_range(1, 12));
                if ($urandom_range(0, 5) == 0)
                    x0 = COORD_W'($urandom_range(2036, 2047));
                else
                    x0 = COORD_W'($urandom_range(0, 2047));
                y0 = COORD_W'($urandom_range(0, 2047));
                for (int i = 0; i < len && int'(x0) + i <= 2047; i++)
                begin
                    send_req(OP_WRITE, x0 + COORD_W'(i), y0,
                             COLOUR_W'($urandom_range(0, 65535)));
                    sent++;
                end
                // how the run ends
                pick = int'($urandom_range(0, 3));
                case (pick)
                    0:
                    begin
                        send_req(OP_FLUSH, COORD_W'($urandom_range(0, 2047)),
                                 COORD_W'($urandom_range(0, 2047)),
                                 COLOUR_W'($urandom_range(0, 65535)));
                        sent++;
                    end
                    1:
                    begin
                        send_req(OP_WRITE, x0 + COORD_W'(len + 1), y0,
                                 COLOUR_W'($urandom_range(0, 65535)));
                        sent++;
                    end
                    2:
                    begin
                        send_req(OP_WRITE, x0 + COORD_W'(len), y0 ^ 11'd1,
                                 COLOUR_W'($urandom_range(0, 65535)));
                        sent++;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_flush_idle();
        test_column_edges();
        test_run_breaks();
        test_mode_drop();
        test_palette_pack();
        test_random_runs(MODE_RGB16, 0, 0, 70, 1'b1);
        test_random_runs(MODE_PAL8, 46, 0, 40, 1'b0);
        test_random_runs(MODE_RGB16, 0, 46, 40, 1'b0);
        test_random_runs(MODE_PAL8, 21, 21, 40, 1'b0);
        send_req(OP_FLUSH, 11'd0, 11'd0, 16'h0000);
        wait_bursts_done();
        if (mismatch_count == 0 && pending_beats.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run time limit
    initial
    begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== pixel_write_combiner_core.f =====
src/pwc_pkg.sv
src/pwc_ram.sv
src/pixel_write_combiner_core.sv
bench/tb_top.sv
